@@ design/gcd_lcm_unit_macros.svh @@
// ----------------------------------------------------------------------------
// gcd_lcm_unit_macros: assertion macros
// Concurrent assertion wrappers shared by the gcd/lcm unit modules. They are
// clocked by clk and disabled while rst_n is low. They compile away for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GLU_ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GLU_ASSERT_NEVER(label, cond, msg) \
    `GLU_ASSERT_PROP(label, !(cond), msg)
`else
`define GLU_ASSERT_PROP(label, prop, msg)
`define GLU_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ design/glu_pkg.sv @@
// ----------------------------------------------------------------------------
// glu_pkg: shared definitions for the gcd/lcm unit
// Operand width, status and command codes, sequencer states and the structs
// that pass between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glu_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);

    typedef logic [OPERAND_BITS-1:0] operand_t;

    localparam operand_t OPERAND_MAX = {OPERAND_BITS{1'b1}};

    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO     = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GCD_WAIT,
        ST_QUO_WAIT,
        ST_MUL_CHECK,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic     start;
        operand_t dividend;
        operand_t divisor;
    } div_req_t;

    typedef struct packed {
        logic     done;
        operand_t quotient;
        operand_t remainder;
    } div_rsp_t;

    typedef struct packed {
        logic     valid;
        operand_t result;
        status_t  status;
    } seq_rsp_t;

endpackage

@@ design/glu_divider.sv @@
// ----------------------------------------------------------------------------
// glu_divider: iterative restoring divider
// Produces quotient and remainder one bit per cycle. done pulses for one
// cycle after the last step; the results then hold until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_unit_macros.svh"

module glu_divider
    import glu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    operand_t              rem_reg;
    operand_t              quo_reg;
    operand_t              div_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [OPERAND_BITS:0] trial;
    logic [OPERAND_BITS:0] diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[OPERAND_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(OPERAND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg <= '0;
            quo_reg <= div_req.dividend;
            div_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[OPERAND_BITS])
            begin
                rem_reg <= diff[OPERAND_BITS-1:0];
                quo_reg <= {quo_reg[OPERAND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[OPERAND_BITS-1:0];
                quo_reg <= {quo_reg[OPERAND_BITS-2:0], 1'b0};
            end
        end
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.quotient  = quo_reg;
    assign div_rsp.remainder = rem_reg;

    `GLU_ASSERT_NEVER(a_no_start_while_busy, div_req.start && busy_reg, "divider restarted while busy")
    `GLU_ASSERT_PROP(a_rem_below_divisor, done_reg |-> (rem_reg < div_reg), "remainder not below divisor")

endmodule

@@ design/glu_sequencer.sv @@
// ----------------------------------------------------------------------------
// glu_sequencer: control and operand registers for gcd/lcm
// Runs Euclid's remainder loop on the shared divider, then for lcm divides a
// by the gcd, multiplies by b and checks the product against the range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_unit_macros.svh"

module glu_sequencer
    import glu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic     command,
    input  operand_t operand_a,
    input  operand_t operand_b,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    output seq_rsp_t seq_rsp,
    input  logic     take
);

    seq_state_t             state_reg;
    seq_state_t             state_next;

    logic                   cmd_reg;
    operand_t               a_reg;
    operand_t               b_reg;
    operand_t               y_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    operand_t               res_reg;
    status_t                st_reg;

    logic                   zero_case;
    logic                   a_greater;
    logic                   rem_zero;
    logic                   res_load;
    operand_t               res_next;
    status_t                st_next;
    logic                   prod_load;

    assign zero_case = (cmd_reg == CMD_GCD) ? (b_reg == '0) : ((a_reg == '0) || (b_reg == '0));
    assign a_greater = a_reg > b_reg;
    assign rem_zero  = div_rsp.remainder == '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = zero_case ? ST_FINISH : ST_GCD_WAIT;
            end
            ST_GCD_WAIT:
            begin
                if (div_rsp.done && rem_zero)
                begin
                    state_next = (cmd_reg == CMD_GCD) ? ST_FINISH : ST_QUO_WAIT;
                end
            end
            ST_QUO_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL_CHECK;
                end
            end
            ST_MUL_CHECK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = a_reg;
        div_req.divisor  = b_reg;
        res_load         = 1'b0;
        res_next         = '0;
        st_next          = STATUS_OK;
        prod_load        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_LOAD:
            begin
                if (zero_case)
                begin
                    res_load = 1'b1;
                    st_next  = STATUS_ZERO;
                end
                else
                begin
                    div_req.start = 1'b1;
                    // lcm runs Euclid on the larger and the smaller operand.
                    if (cmd_reg == CMD_LCM && !a_greater)
                    begin
                        div_req.dividend = b_reg;
                        div_req.divisor  = a_reg;
                    end
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!rem_zero)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = y_reg;
                        div_req.divisor  = div_rsp.remainder;
                    end
                    else if (cmd_reg == CMD_GCD)
                    begin
                        res_load = 1'b1;
                        res_next = y_reg;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = a_reg;
                        div_req.divisor  = y_reg;
                    end
                end
            end
            ST_QUO_WAIT:
            begin
                prod_load = div_rsp.done;
            end
            ST_MUL_CHECK:
            begin
                res_load = 1'b1;
                if (|prod_reg[PROD_BITS-1:OPERAND_BITS])
                begin
                    res_next = OPERAND_MAX;
                    st_next  = STATUS_OVERFLOW;
                end
                else
                begin
                    res_next = prod_reg[OPERAND_BITS-1:0];
                end
            end
            ST_FINISH:
            begin
                req_ready = 1'b0;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= command;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
        if (div_req.start)
        begin
            y_reg <= div_req.divisor;
        end
        if (prod_load)
        begin
            prod_reg <= PROD_BITS'(div_rsp.quotient) * PROD_BITS'(b_reg);
        end
        if (res_load)
        begin
            res_reg <= res_next;
            st_reg  <= st_next;
        end
    end

    assign seq_rsp.valid  = (state_reg == ST_FINISH);
    assign seq_rsp.result = res_reg;
    assign seq_rsp.status = st_reg;

    `GLU_ASSERT_PROP(a_ok_result_nonzero, (seq_rsp.valid && st_reg == STATUS_OK) |-> (res_reg != '0), "ok result is zero")

endmodule

@@ design/gcd_lcm_unit.sv @@
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// A zero operand (b for gcd, a or b for lcm) skips the divider; gcd runs
// one divide per Euclid remainder step, and lcm adds a divide for the
// quotient and the product check. Every remainder goes through one shared
// bit-serial divider, so one request is in work at a time: the next
// request is taken only after the result moves to the output register.
// Reset (rst_n, asynchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit
    import glu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic     command,
    input  operand_t operand_a,
    input  operand_t operand_b,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output operand_t result,
    output logic [1:0] status
);

    div_req_t   div_req;
    div_rsp_t   div_rsp;
    seq_rsp_t   seq_rsp;
    logic       take;

    logic       rsp_valid_reg;
    operand_t   result_reg;
    logic [1:0] status_reg;

    glu_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .seq_rsp   (seq_rsp),
        .take      (take)
    );

    glu_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // The output register frees the sequencer as soon as the result moves in.
    assign take = seq_rsp.valid && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= seq_rsp.result;
            status_reg <= seq_rsp.status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

    `GLU_ASSERT_PROP(a_busy_after_request, (req_valid && req_ready) |=> !req_ready, "ready right after a request")

endmodule

@@ bench/gcd_lcm_checker.sv @@
// ----------------------------------------------------------------------------
// gcd_lcm_checker: result checker for the gcd/lcm unit
// Watches both channels of the unit. Every accepted request is turned into
// the expected gcd or lcm and status, and every accepted result is compared
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_checker
    import glu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        command,
    input  operand_t    operand_a,
    input  operand_t    operand_b,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  operand_t    result,
    input  logic [1:0]  status,
    output int unsigned mismatches,
    output int unsigned answers_pending
);

    typedef struct packed {
        operand_t value;
        status_t  code;
    } answer_t;

    answer_t     answers_due[$];
    answer_t     oldest;
    int unsigned fail_count = 0;
    int unsigned due_count  = 0;

    assign mismatches      = fail_count;
    assign answers_pending = due_count;

    // Euclid with repeated remainders; y must be nonzero.
    function automatic operand_t euclid_gcd(operand_t x, operand_t y);
        operand_t r;
        r = x % y;
        while (r != '0)
        begin
            x = y;
            y = r;
            r = x % y;
        end
        return y;
    endfunction

    function automatic answer_t gcd_lcm_of(logic cmd, operand_t a, operand_t b);
        answer_t              ans;
        operand_t             g;
        logic [PROD_BITS-1:0] product;
        ans.value = '0;
        ans.code  = STATUS_OK;
        if (cmd == CMD_GCD)
        begin
            if (b == '0)
                ans.code = STATUS_ZERO;
            else
                ans.value = euclid_gcd(a, b);
        end
        else if (a == '0 || b == '0)
        begin
            ans.code = STATUS_ZERO;
        end
        else
        begin
            g       = euclid_gcd(a, b);
            // The product is formed at double width so that the range check
            // sees the true lcm.
            product = PROD_BITS'(a / g) * PROD_BITS'(b);
            if (product > PROD_BITS'(OPERAND_MAX))
            begin
                ans.value = OPERAND_MAX;
                ans.code  = STATUS_OVERFLOW;
            end
            else
            begin
                ans.value = product[OPERAND_BITS-1:0];
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // A result never leaves in the same cycle as its own request, so
            // the result side is checked before the new request is queued.
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: result %0d status %0d arrived with none expected",
                             $time, result, status);
                end
                else
                begin
                    oldest = answers_due.pop_front();
                    if (result !== oldest.value)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: result expected %0d, actual %0d",
                                 $time, oldest.value, result);
                    end
                    if (status !== oldest.code)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, oldest.code, status);
                    end
                end
            end
            if (req_valid && req_ready)
                answers_due.push_back(gcd_lcm_of(command, operand_a, operand_b));
            due_count = answers_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for the gcd/lcm unit
// Sends a directed set of edge-case requests and then constrained-by-hand
// random requests through three idling phases, including one long stall of
// the result channel. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import glu_pkg::*;
();

    // Slowest request is about 45 Euclid steps plus the lcm tail.
    localparam int unsigned CYCLE_LIMIT      = 9_000_000;
    localparam int unsigned HOLD_CYCLES      = 3000;
    localparam int unsigned RANDOM_PER_PHASE = 392;
    localparam operand_t    FIB_46           = 31'd1836311903;
    localparam operand_t    FIB_45           = 31'd1134903170;
    localparam operand_t    TWO_POW_30       = 31'd1073741824;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        command   = CMD_GCD;
    operand_t    operand_a = '0;
    operand_t    operand_b = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    operand_t    result;
    logic [1:0]  status;
    int unsigned mismatches;
    int unsigned answers_pending;
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 80;
    logic        hold_go       = 1'b0;
    logic        hold_rsp      = 1'b0;
    int unsigned cycle_count   = 0;

    always #10 clk = ~clk;

    gcd_lcm_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .result    (result),
        .status    (status)
    );

    gcd_lcm_checker answer_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .command         (command),
        .operand_a       (operand_a),
        .operand_b       (operand_b),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .result          (result),
        .status          (status),
        .mismatches      (mismatches),
        .answers_pending (answers_pending)
    );

    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Long stall of the result side while requests keep coming.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("gcd_lcm_unit regression: fail");
            $finish;
        end
    end

    function automatic operand_t value_of_width(int unsigned w);
        return operand_t'($urandom()) & (OPERAND_MAX >> (OPERAND_BITS - w));
    endfunction

    task automatic offer_request(input logic cmd, input operand_t a, input operand_t b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic offer_random_request();
        logic        cmd;
        operand_t    a;
        operand_t    b;
        operand_t    g;
        operand_t    swap;
        int unsigned kind;
        int unsigned wg;
        cmd  = $urandom_range(0, 1) ? CMD_LCM : CMD_GCD;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            a = value_of_width(OPERAND_BITS);
            b = value_of_width(OPERAND_BITS);
        end
        else if (kind < 60)
        begin
            a = value_of_width($urandom_range(1, OPERAND_BITS));
            b = value_of_width($urandom_range(1, OPERAND_BITS));
        end
        else if (kind < 85)
        begin
            // Shared factor, so that gcd is large and lcm often fits.
            wg = $urandom_range(1, 20);
            g  = value_of_width(wg);
            if (g == '0)
                g = operand_t'(1);
            a = g * value_of_width($urandom_range(1, OPERAND_BITS - wg));
            b = g * value_of_width($urandom_range(1, OPERAND_BITS - wg));
        end
        else if (kind < 93)
        begin
            a = value_of_width($urandom_range(1, OPERAND_BITS));
            b = value_of_width($urandom_range(1, OPERAND_BITS));
            if ($urandom_range(0, 1))
                a = '0;
            else
                b = '0;
        end
        else
        begin
            a = OPERAND_MAX - operand_t'($urandom_range(0, 3));
            b = operand_t'(1) << $urandom_range(0, OPERAND_BITS - 1);
            if ($urandom_range(0, 1))
            begin
                swap = a;
                a    = b;
                b    = swap;
            end
        end
        offer_request(cmd, a, b);
    endtask

    initial
    begin
        int unsigned n;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer_request(CMD_GCD, '0, '0);
        offer_request(CMD_GCD, 31'd5, '0);
        offer_request(CMD_GCD, '0, 31'd7);
        offer_request(CMD_GCD, '0, OPERAND_MAX);
        offer_request(CMD_GCD, OPERAND_MAX, OPERAND_MAX);
        offer_request(CMD_GCD, OPERAND_MAX, 31'd1);
        offer_request(CMD_GCD, 31'd1, OPERAND_MAX);
        offer_request(CMD_GCD, 31'd12, 31'd18);
        offer_request(CMD_GCD, 31'd18, 31'd12);
        offer_request(CMD_GCD, FIB_46, FIB_45);
        offer_request(CMD_GCD, TWO_POW_30, TWO_POW_30 >> 1);
        offer_request(CMD_LCM, '0, 31'd5);
        offer_request(CMD_LCM, 31'd5, '0);
        offer_request(CMD_LCM, '0, '0);
        offer_request(CMD_LCM, 31'd1, 31'd1);
        offer_request(CMD_LCM, 31'd4, 31'd6);
        offer_request(CMD_LCM, OPERAND_MAX, 31'd1);
        offer_request(CMD_LCM, 31'd1, OPERAND_MAX);
        offer_request(CMD_LCM, OPERAND_MAX, OPERAND_MAX);
        offer_request(CMD_LCM, OPERAND_MAX, 31'd2);
        offer_request(CMD_LCM, 31'd65536, 31'd32768);
        // Coprime neighbors just below and just above the operand range.
        offer_request(CMD_LCM, 31'd46341, 31'd46340);
        offer_request(CMD_LCM, 31'd46341, 31'd46342);
        offer_request(CMD_LCM, FIB_46, FIB_45);

        for (n = 0; n < RANDOM_PER_PHASE; n++)
            offer_random_request();

        send_idle_pct = 80;
        recv_idle_pct = 8;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            offer_random_request();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            offer_random_request();

        @(negedge clk);
        req_valid <= 1'b0;

        wait (answers_pending == 0);
        repeat (64) @(posedge clk);
        if (mismatches == 0 && answers_pending == 0)
            $display("gcd_lcm_unit regression: pass");
        else
            $display("gcd_lcm_unit regression: fail");
        $finish;
    end

endmodule
